>>> rtl/core/qlte_pkg.sv
package qlte_pkg;

    localparam int STATE_COUNT  = 8;
    localparam int ACTION_COUNT = 8;
    localparam int ENTRY_COUNT  = STATE_COUNT * ACTION_COUNT;

    localparam int STATE_W = $clog2(STATE_COUNT);
    localparam int ACT_W   = $clog2(ACTION_COUNT);
    localparam int ADDR_W  = $clog2(ENTRY_COUNT);
    localparam int CNT_W   = $clog2(ACTION_COUNT + 1);

    // fixed field widths
    localparam int IDX_W    = 3;
    localparam int Q_W      = 32;
    localparam int FRAC_W   = 16;
    localparam int CFG_IDX_W = 2;

    // diff = reward + scaled - cur stays within +/- 3 * 2^31
    localparam int MUL_A_W = Q_W + 2;
    localparam int PROD_W  = MUL_A_W + FRAC_W + 1;
    localparam int SCL_W   = PROD_W - FRAC_W;
    localparam int SUM_W   = SCL_W + 1;

    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(32768);
    localparam logic signed [Q_W-1:0]    Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0]    Q_MIN = 32'sh8000_0000;

    localparam logic CMD_CHOOSE = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_THRESHOLD = 2'd2;

    localparam logic [FRAC_W-1:0] RST_LEARNING_RATE     = 16'd6554;
    localparam logic [FRAC_W-1:0] RST_DISCOUNT          = 16'd58982;
    localparam logic [FRAC_W-1:0] RST_EXPLORE_THRESHOLD = 16'd13107;

    // value < 8 and count >= 2: at most three subtractions
    function automatic logic [STATE_W-1:0] reduce_state(input logic [IDX_W-1:0] v);
        logic [8:0] t;
        t = 9'(v);
        for (int i = 0; i < 4; i++) begin
            if (t >= 9'(STATE_COUNT)) begin
                t = t - 9'(STATE_COUNT);
            end
        end
        return STATE_W'(t);
    endfunction

    function automatic logic [ACT_W-1:0] reduce_action(input logic [IDX_W-1:0] v);
        logic [8:0] t;
        t = 9'(v);
        for (int i = 0; i < 4; i++) begin
            if (t >= 9'(ACTION_COUNT)) begin
                t = t - 9'(ACTION_COUNT);
            end
        end
        return ACT_W'(t);
    endfunction

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [STATE_W-1:0] row,
                                                     input logic [ACT_W-1:0] act);
        logic [ADDR_W-1:0] r;
        r = ADDR_W'(row);
        return r * ADDR_W'(ACTION_COUNT) + ADDR_W'(act);
    endfunction

endpackage

>>> rtl/core/q_learning_table_engine.sv
// Choose, exploring:  S_PICK reads the picked entry, S_PICK_W captures it, S_DONE registers the result.
// Choose, greedy:     row scan, one entry of the row read per cycle through the table RAM.
// Update:             row scan, entry read, then two passes
//                     through the single shared multiplier.
// One transaction at a time; a held result delays completion only at the last step.
// Synchronous reset: registers to defaults, table reads as zero (per-entry valid bits).
module q_learning_table_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_cmd,
    input  logic        [qlte_pkg::IDX_W-1:0]   i_cur_state,
    input  logic        [qlte_pkg::IDX_W-1:0]   i_taken_action,
    input  logic        [qlte_pkg::IDX_W-1:0]   i_following_state,
    input  logic signed [qlte_pkg::Q_W-1:0]     i_reward_value,
    input  logic        [qlte_pkg::FRAC_W-1:0]  i_random_draw,
    input  logic        [qlte_pkg::IDX_W-1:0]   i_random_pick,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic        [qlte_pkg::IDX_W-1:0]   o_chosen_action,
    output logic                                o_explored,
    output logic signed [qlte_pkg::Q_W-1:0]     o_entry_value,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic        [qlte_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [qlte_pkg::FRAC_W-1:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_PICK_W,
        S_CUR,
        S_CUR_W,
        S_GAM,
        S_ALPHA,
        S_NEW,
        S_DONE
    } t_state;

    t_state r_state;

    logic [qlte_pkg::FRAC_W-1:0] r_alpha;
    logic [qlte_pkg::FRAC_W-1:0] r_gamma;
    logic [qlte_pkg::FRAC_W-1:0] r_epsilon;

    logic                               r_cmd;
    logic                               r_explore;
    logic [qlte_pkg::STATE_W-1:0]       r_cur_row;
    logic [qlte_pkg::STATE_W-1:0]       r_scan_row;
    logic [qlte_pkg::ACT_W-1:0]         r_act;
    logic signed [qlte_pkg::Q_W-1:0]    r_reward;
    logic [qlte_pkg::CNT_W-1:0]         r_cnt;
    logic signed [qlte_pkg::Q_W-1:0]    r_best;
    logic [qlte_pkg::ACT_W-1:0]         r_best_idx;
    logic signed [qlte_pkg::Q_W-1:0]    r_cur;
    logic signed [qlte_pkg::MUL_A_W-1:0] r_diff;

    logic [qlte_pkg::ENTRY_COUNT-1:0]   r_valid;
    logic                               r_rd_valid;

    logic                               r_out_valid;
    logic [qlte_pkg::IDX_W-1:0]         r_out_act;
    logic                               r_out_expl;
    logic signed [qlte_pkg::Q_W-1:0]    r_out_value;

    logic [qlte_pkg::ADDR_W-1:0]        w_raddr;
    logic [qlte_pkg::ADDR_W-1:0]        w_waddr;
    logic [qlte_pkg::Q_W-1:0]           w_ram_q;
    logic signed [qlte_pkg::Q_W-1:0]    w_q;
    logic                               w_we;
    logic signed [qlte_pkg::Q_W-1:0]    w_new;

    logic signed [qlte_pkg::MUL_A_W-1:0] w_mul_a;
    logic [qlte_pkg::FRAC_W-1:0]         w_mul_b;
    logic signed [qlte_pkg::PROD_W-1:0]  w_prod;
    logic signed [qlte_pkg::PROD_W-1:0]  w_rnd;
    logic signed [qlte_pkg::SCL_W-1:0]   w_scaled;
    logic signed [qlte_pkg::SUM_W-1:0]   w_sum;
    logic [qlte_pkg::ACT_W-1:0]          w_proc_idx;
    logic                                w_in_take;
    logic                                w_explore_in;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_take   = i_in_valid && (r_state == S_IDLE);
    assign w_explore_in = (i_cmd == qlte_pkg::CMD_CHOOSE) && (i_random_draw < r_epsilon);

    // table access
    assign w_raddr = (r_state == S_SCAN)
                   ? qlte_pkg::entry_addr(r_scan_row, r_cnt[qlte_pkg::ACT_W-1:0])
                   : qlte_pkg::entry_addr(r_cur_row, r_act);
    assign w_waddr = qlte_pkg::entry_addr(r_cur_row, r_act);
    assign w_we    = (r_state == S_NEW);
    assign w_q     = r_rd_valid ? $signed(w_ram_q) : '0;

    qlte_ram #(
        .WIDTH (qlte_pkg::Q_W),
        .DEPTH (qlte_pkg::ENTRY_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_new),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    // shared multiplier: gamma * max first, then alpha * diff
    assign w_mul_a = (r_state == S_ALPHA) ? r_diff : qlte_pkg::MUL_A_W'(r_best);
    assign w_mul_b = (r_state == S_ALPHA) ? r_alpha : r_gamma;

    qlte_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // round half up, then drop the fraction (floor)
    assign w_rnd    = w_prod + qlte_pkg::ROUND_BIAS;
    assign w_scaled = $signed(w_rnd[qlte_pkg::PROD_W-1:qlte_pkg::FRAC_W]);

    always_comb begin
        w_sum = qlte_pkg::SUM_W'(r_cur) + qlte_pkg::SUM_W'(w_scaled);
        if (w_sum > qlte_pkg::SUM_W'(qlte_pkg::Q_MAX)) begin
            w_new = qlte_pkg::Q_MAX;
        end else if (w_sum < qlte_pkg::SUM_W'(qlte_pkg::Q_MIN)) begin
            w_new = qlte_pkg::Q_MIN;
        end else begin
            w_new = qlte_pkg::Q_W'(w_sum);
        end
    end

    assign w_proc_idx = qlte_pkg::ACT_W'(r_cnt - qlte_pkg::CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_valid     <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_alpha     <= qlte_pkg::RST_LEARNING_RATE;
            r_gamma     <= qlte_pkg::RST_DISCOUNT;
            r_epsilon   <= qlte_pkg::RST_EXPLORE_THRESHOLD;
        end else begin
            r_rd_valid <= r_valid[w_raddr];

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    qlte_pkg::CFG_LEARNING_RATE:     r_alpha   <= i_cfg_data;
                    qlte_pkg::CFG_DISCOUNT:          r_gamma   <= i_cfg_data;
                    qlte_pkg::CFG_EXPLORE_THRESHOLD: r_epsilon <= i_cfg_data;
                    default: ;
                endcase
            end

            // in S_DONE the result register is handled by the state arm
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        r_cmd      <= i_cmd;
                        r_explore  <= w_explore_in;
                        r_cur_row  <= qlte_pkg::reduce_state(i_cur_state);
                        r_reward   <= i_reward_value;
                        r_cnt      <= '0;
                        if (i_cmd == qlte_pkg::CMD_UPDATE) begin
                            r_scan_row <= qlte_pkg::reduce_state(i_following_state);
                            r_act      <= qlte_pkg::reduce_action(i_taken_action);
                            r_state    <= S_SCAN;
                        end else if (w_explore_in) begin
                            r_act   <= qlte_pkg::reduce_action(i_random_pick);
                            r_state <= S_PICK;
                        end else begin
                            r_scan_row <= qlte_pkg::reduce_state(i_cur_state);
                            r_state    <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // read issued at r_cnt, data of r_cnt-1 compared this cycle
                    if (r_cnt != '0) begin
                        if (w_proc_idx == '0 || w_q > r_best) begin
                            r_best     <= w_q;
                            r_best_idx <= w_proc_idx;
                        end
                    end
                    if (r_cnt == qlte_pkg::CNT_W'(qlte_pkg::ACTION_COUNT)) begin
                        r_state <= (r_cmd == qlte_pkg::CMD_UPDATE) ? S_CUR : S_DONE;
                    end else begin
                        r_cnt <= r_cnt + qlte_pkg::CNT_W'(1);
                    end
                end
                S_PICK: begin
                    r_state <= S_PICK_W;
                end
                S_PICK_W: begin
                    r_best  <= w_q;
                    r_state <= S_DONE;
                end
                S_CUR: begin
                    r_state <= S_CUR_W;
                end
                S_CUR_W: begin
                    r_cur   <= w_q;
                    r_state <= S_GAM;
                end
                S_GAM: begin
                    r_diff  <= qlte_pkg::MUL_A_W'(qlte_pkg::SCL_W'(r_reward) + w_scaled
                                                  - qlte_pkg::SCL_W'(r_cur));
                    r_state <= S_ALPHA;
                end
                S_ALPHA: begin
                    r_state <= S_NEW;
                end
                S_NEW: begin
                    r_valid[w_waddr] <= 1'b1;
                    r_best           <= w_new;
                    r_state          <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_expl  <= r_explore;
                        r_out_value <= r_best;
                        if (r_cmd == qlte_pkg::CMD_CHOOSE && !r_explore) begin
                            r_out_act <= qlte_pkg::IDX_W'(r_best_idx);
                        end else begin
                            r_out_act <= qlte_pkg::IDX_W'(r_act);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_chosen_action = r_out_act;
    assign o_explored      = r_out_expl;
    assign o_entry_value   = r_out_value;

endmodule

>>> rtl/core/qlte_ram.sv
module qlte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/qlte_mul.sv
module qlte_mul (
    input  logic                               i_clk,
    input  logic signed [qlte_pkg::MUL_A_W-1:0] i_a,
    input  logic        [qlte_pkg::FRAC_W-1:0]  i_b,
    output logic signed [qlte_pkg::PROD_W-1:0]  o_prod
);

    logic signed [qlte_pkg::PROD_W-1:0] r_prod;

    // fraction operand is unsigned: zero bit on top makes it a positive signed value
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * $signed({1'b0, i_b});
    end

    assign o_prod = r_prod;

endmodule

>>> tb/q_learning_table_engine_test.sv
module q_learning_table_engine_test;

    localparam logic [qlte_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic                              cmd;
        logic [qlte_pkg::IDX_W-1:0]        state;
        logic [qlte_pkg::IDX_W-1:0]        action;
        logic [qlte_pkg::IDX_W-1:0]        follow_state;
        logic signed [qlte_pkg::Q_W-1:0]   reward;
        logic [qlte_pkg::FRAC_W-1:0]       draw;
        logic [qlte_pkg::IDX_W-1:0]        pick;
    } t_q_command;

    typedef struct packed {
        logic [qlte_pkg::IDX_W-1:0]        action;
        logic                              explored;
        logic signed [qlte_pkg::Q_W-1:0]   value;
    } t_q_outcome;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_stall;
    logic                               i_cmd = qlte_pkg::CMD_CHOOSE;
    logic [qlte_pkg::IDX_W-1:0]         i_cur_state = '0;
    logic [qlte_pkg::IDX_W-1:0]         i_taken_action = '0;
    logic [qlte_pkg::IDX_W-1:0]         i_following_state = '0;
    logic signed [qlte_pkg::Q_W-1:0]    i_reward_value = '0;
    logic [qlte_pkg::FRAC_W-1:0]        i_random_draw = '0;
    logic [qlte_pkg::IDX_W-1:0]         i_random_pick = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic [qlte_pkg::IDX_W-1:0]         o_chosen_action;
    logic                               o_explored;
    logic signed [qlte_pkg::Q_W-1:0]    o_entry_value;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [qlte_pkg::CFG_IDX_W-1:0]     i_cfg_index = qlte_pkg::CFG_LEARNING_RATE;
    logic [qlte_pkg::FRAC_W-1:0]        i_cfg_data = '0;

    q_learning_table_engine dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_cur_state       (i_cur_state),
        .i_taken_action    (i_taken_action),
        .i_following_state (i_following_state),
        .i_reward_value    (i_reward_value),
        .i_random_draw     (i_random_draw),
        .i_random_pick     (i_random_pick),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_chosen_action   (o_chosen_action),
        .o_explored        (o_explored),
        .o_entry_value     (o_entry_value),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // table and register copies used to predict each transaction
    logic signed [qlte_pkg::Q_W-1:0] q_model [qlte_pkg::STATE_COUNT][qlte_pkg::ACTION_COUNT];
    logic [qlte_pkg::FRAC_W-1:0]     alpha_frac = qlte_pkg::RST_LEARNING_RATE;
    logic [qlte_pkg::FRAC_W-1:0]     gamma_frac = qlte_pkg::RST_DISCOUNT;
    logic [qlte_pkg::FRAC_W-1:0]     epsilon_frac = qlte_pkg::RST_EXPLORE_THRESHOLD;

    t_q_command pending_commands[$];
    t_q_outcome predicted_outcomes[$];
    t_q_command in_flight;
    int         send_gap = 0;
    int         send_mode = 1;
    int         recv_hold = 0;
    int         recv_mode = 1;
    int         mismatch_count = 0;

    initial begin
        for (int s = 0; s < qlte_pkg::STATE_COUNT; s++) begin
            for (int a = 0; a < qlte_pkg::ACTION_COUNT; a++) begin
                q_model[s][a] = '0;
            end
        end
    end

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // floor((x + 0.5) in Q16 units), arithmetic shift gives the floor
    function automatic longint round_q16(input longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic t_q_outcome run_q_step(input t_q_command c);
        t_q_outcome o;
        int         row;
        int         nrow;
        int         act;
        int         a;
        longint     best;
        longint     cur;
        longint     diff;
        longint     nv;
        row = int'(c.state) % qlte_pkg::STATE_COUNT;
        o.explored = 1'b0;
        if (c.cmd == qlte_pkg::CMD_CHOOSE) begin
            if (c.draw < epsilon_frac) begin
                act = int'(c.pick) % qlte_pkg::ACTION_COUNT;
                o.explored = 1'b1;
            end else begin
                act = 0;
                for (a = 1; a < qlte_pkg::ACTION_COUNT; a++) begin
                    if (q_model[row][a] > q_model[row][act]) begin
                        act = a;
                    end
                end
            end
            o.value = q_model[row][act];
        end else begin
            nrow = int'(c.follow_state) % qlte_pkg::STATE_COUNT;
            act = int'(c.action) % qlte_pkg::ACTION_COUNT;
            best = q_model[nrow][0];
            for (a = 1; a < qlte_pkg::ACTION_COUNT; a++) begin
                if (q_model[nrow][a] > best) begin
                    best = q_model[nrow][a];
                end
            end
            cur = q_model[row][act];
            diff = longint'($signed(c.reward)) + round_q16(longint'(gamma_frac) * best) - cur;
            nv = cur + round_q16(longint'(alpha_frac) * diff);
            if (nv > longint'(qlte_pkg::Q_MAX)) begin
                nv = longint'(qlte_pkg::Q_MAX);
            end
            if (nv < longint'(qlte_pkg::Q_MIN)) begin
                nv = longint'(qlte_pkg::Q_MIN);
            end
            q_model[row][act] = nv[qlte_pkg::Q_W-1:0];
            o.value = nv[qlte_pkg::Q_W-1:0];
        end
        o.action = qlte_pkg::IDX_W'(act);
        return o;
    endfunction

    function automatic int draw_gap(input int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 18);
            default: return $urandom_range(0, 2);
        endcase
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted_outcomes.push_back(run_q_step(in_flight));
                if ($urandom_range(0, 47) == 0) begin
                    send_mode = $urandom_range(0, 2);
                end
                send_gap = draw_gap(send_mode);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_commands.size() != 0) begin
                    in_flight = pending_commands.pop_front();
                    i_cmd <= in_flight.cmd;
                    i_cur_state <= in_flight.state;
                    i_taken_action <= in_flight.action;
                    i_following_state <= in_flight.follow_state;
                    i_reward_value <= in_flight.reward;
                    i_random_draw <= in_flight.draw;
                    i_random_pick <= in_flight.pick;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: holds each result for a drawn number of cycles, then takes it
    always @(posedge i_clk) begin
        t_q_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_outcomes.size() == 0) begin
                $error("unexpected result: chosen_action %0d explored %0d entry_value %0d",
                       o_chosen_action, o_explored, o_entry_value);
                mismatch_count++;
            end else begin
                want = predicted_outcomes.pop_front();
                if (o_chosen_action !== want.action) begin
                    $error("chosen_action: expected %0d, actual %0d",
                           want.action, o_chosen_action);
                    mismatch_count++;
                end
                if (o_explored !== want.explored) begin
                    $error("explored: expected %0d, actual %0d", want.explored, o_explored);
                    mismatch_count++;
                end
                if (o_entry_value !== want.value) begin
                    $error("entry_value: expected %0d, actual %0d",
                           $signed(want.value), o_entry_value);
                    mismatch_count++;
                end
            end
            if ($urandom_range(0, 47) == 0) begin
                recv_mode = $urandom_range(0, 2);
            end
            recv_hold = draw_gap(recv_mode);
        end else if (o_out_valid && recv_hold != 0) begin
            recv_hold--;
        end
        i_out_stall <= (recv_hold != 0);
    end

    task automatic add_command(input logic cmd, input int s, input int a, input int ns,
                               input logic signed [qlte_pkg::Q_W-1:0] reward,
                               input int draw, input int pick);
        t_q_command c;
        c.cmd = cmd;
        c.state = qlte_pkg::IDX_W'(s);
        c.action = qlte_pkg::IDX_W'(a);
        c.follow_state = qlte_pkg::IDX_W'(ns);
        c.reward = reward;
        c.draw = qlte_pkg::FRAC_W'(draw);
        c.pick = qlte_pkg::IDX_W'(pick);
        pending_commands.push_back(c);
    endtask

    function automatic t_q_command random_command();
        t_q_command c;
        c.cmd = $urandom_range(0, 1) ? qlte_pkg::CMD_UPDATE : qlte_pkg::CMD_CHOOSE;
        c.state = qlte_pkg::IDX_W'($urandom_range(0, 7));
        c.action = qlte_pkg::IDX_W'($urandom_range(0, 7));
        c.follow_state = ($urandom_range(0, 3) == 0) ? c.state
                                                     : qlte_pkg::IDX_W'($urandom_range(0, 7));
        case ($urandom_range(0, 6))
            0: c.reward = qlte_pkg::Q_MAX;
            1: c.reward = qlte_pkg::Q_MIN;
            2: c.reward = 32'sd0;
            3: c.reward = 32'($urandom_range(0, 2097152)) - 32'd1048576;
            4: c.reward = {16'($urandom_range(0, 31)) - 16'd16, 16'd0};
            default: c.reward = $urandom();
        endcase
        case ($urandom_range(0, 5))
            0: c.draw = epsilon_frac + qlte_pkg::FRAC_W'($urandom_range(0, 3))
                        - qlte_pkg::FRAC_W'(2);
            1: c.draw = '0;
            2: c.draw = '1;
            default: c.draw = qlte_pkg::FRAC_W'($urandom());
        endcase
        c.pick = qlte_pkg::IDX_W'($urandom_range(0, 7));
        return c;
    endfunction

    function automatic logic [qlte_pkg::FRAC_W-1:0] random_fraction();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            default: return qlte_pkg::FRAC_W'($urandom());
        endcase
    endfunction

    task automatic write_reg(input logic [qlte_pkg::CFG_IDX_W-1:0] idx,
                             input logic [qlte_pkg::FRAC_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            qlte_pkg::CFG_LEARNING_RATE:     alpha_frac = data;
            qlte_pkg::CFG_DISCOUNT:          gamma_frac = data;
            qlte_pkg::CFG_EXPLORE_THRESHOLD: epsilon_frac = data;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_commands.size() != 0 || i_in_valid || predicted_outcomes.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int phase;
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, all-zero table: ties, both sides of the threshold
        @(negedge i_clk);
        add_command(qlte_pkg::CMD_CHOOSE, 0, 0, 0, 0, 65535, 3);
        add_command(qlte_pkg::CMD_CHOOSE, 7, 0, 0, 0, 0, 7);
        add_command(qlte_pkg::CMD_CHOOSE, 3, 0, 0, 0, 13106, 5);
        add_command(qlte_pkg::CMD_CHOOSE, 3, 0, 0, 0, 13107, 5);
        add_command(qlte_pkg::CMD_UPDATE, 7, 7, 0, qlte_pkg::Q_MAX, 0, 0);
        add_command(qlte_pkg::CMD_UPDATE, 7, 3, 7, qlte_pkg::Q_MIN, 0, 0);
        add_command(qlte_pkg::CMD_CHOOSE, 7, 0, 0, 0, 65535, 0);
        add_command(qlte_pkg::CMD_UPDATE, 0, 5, 7, 0, 65535, 7);
        add_command(qlte_pkg::CMD_CHOOSE, 0, 0, 0, 0, 40000, 0);
        wait_drained();

        // full-scale alpha and gamma, no exploration; unused index must not land
        write_reg(qlte_pkg::CFG_LEARNING_RATE, '1);
        write_reg(qlte_pkg::CFG_DISCOUNT, '1);
        write_reg(qlte_pkg::CFG_EXPLORE_THRESHOLD, '0);
        write_reg(CFG_UNUSED, '1);
        @(negedge i_clk);
        // self-loop on a growing entry pushes past the positive limit
        for (int k = 0; k < 3; k++) begin
            add_command(qlte_pkg::CMD_UPDATE, 4, 2, 4, qlte_pkg::Q_MAX, 0, 0);
        end
        add_command(qlte_pkg::CMD_CHOOSE, 4, 0, 0, 0, 0, 6);
        // fill a row with large negatives, then one more drives below the limit
        for (int k = 0; k < qlte_pkg::ACTION_COUNT; k++) begin
            add_command(qlte_pkg::CMD_UPDATE, 2, k, 3, qlte_pkg::Q_MIN, 0, 0);
        end
        add_command(qlte_pkg::CMD_UPDATE, 2, 0, 2, qlte_pkg::Q_MIN, 0, 0);
        add_command(qlte_pkg::CMD_CHOOSE, 2, 0, 0, 0, 65535, 0);
        wait_drained();

        write_reg(qlte_pkg::CFG_LEARNING_RATE, '0);
        write_reg(qlte_pkg::CFG_DISCOUNT, '0);
        write_reg(qlte_pkg::CFG_EXPLORE_THRESHOLD, '1);
        @(negedge i_clk);
        add_command(qlte_pkg::CMD_UPDATE, 1, 1, 4, qlte_pkg::Q_MAX, 0, 0);
        add_command(qlte_pkg::CMD_CHOOSE, 4, 0, 0, 0, 65534, 6);
        add_command(qlte_pkg::CMD_CHOOSE, 4, 0, 0, 0, 65535, 6);
        wait_drained();

        for (phase = 0; phase < 6; phase++) begin
            write_reg(qlte_pkg::CFG_LEARNING_RATE, random_fraction());
            write_reg(qlte_pkg::CFG_DISCOUNT, random_fraction());
            write_reg(qlte_pkg::CFG_EXPLORE_THRESHOLD, random_fraction());
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_UNUSED, qlte_pkg::FRAC_W'($urandom()));
            end
            @(negedge i_clk);
            for (n = 0; n < 275; n++) begin
                pending_commands.push_back(random_command());
            end
            wait_drained();
        end

        repeat (qlte_pkg::ACTION_COUNT + 16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("q_learning_table_engine_test OK");
        end else begin
            $display("q_learning_table_engine_test NOT OK");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("q_learning_table_engine_test NOT OK");
        $finish;
    end

endmodule
